### rtl/pfba_pkg.sv
// Package for the page frame bitmap allocator.
// Holds sizes, operation and status codes, sequencer states and the word unit structs.
// No dependencies.
package pfba_pkg;

  localparam int MAX_WORDS = 1024;
  localparam int WORD_W    = 32;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int ADDR_W    = $clog2(MAX_WORDS);
  localparam int CFG_W     = 11;
  localparam int PAGE_W    = 15;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);
  localparam logic [CFG_W-1:0] MAX_COUNT = CFG_W'(MAX_WORDS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_WORDS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC_PAGE  = 2'd0,
    OP_ALLOC_BLOCK = 2'd1,
    OP_FREE_PAGE   = 2'd2,
    OP_UNUSED      = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_NONE  = 2'd1,
    STAT_RANGE = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [BIT_W-1:0] bit_sel;
  } unit_ctl_t;

  typedef struct packed {
    logic              hit;
    logic [BIT_W-1:0]  bit_idx;
    logic [WORD_W-1:0] new_word;
  } unit_res_t;

endpackage

### rtl/pfba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No package dependencies.
module pfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/pfba_word_unit.sv
// Shared word unit: tests one bitmap word and forms its updated value.
// Depends on pfba_pkg.
module pfba_word_unit (
  input  logic [pfba_pkg::WORD_W-1:0] word,
  input  pfba_pkg::unit_ctl_t         ctl,
  output pfba_pkg::unit_res_t         res
);

  logic [pfba_pkg::BIT_W-1:0] low_clear;

  always_comb begin
    low_clear = '0;
    for (int b = pfba_pkg::WORD_W - 1; b >= 0; b--) begin
      if (!word[b]) begin
        low_clear = pfba_pkg::BIT_W'(b);
      end
    end
  end

  always_comb begin
    res = '0;
    unique case (ctl.op)
      pfba_pkg::OP_ALLOC_PAGE: begin
        res.hit      = ~&word;
        res.bit_idx  = low_clear;
        res.new_word = word | (pfba_pkg::WORD_W'(1) << low_clear);
      end
      pfba_pkg::OP_ALLOC_BLOCK: begin
        res.hit      = ~|word;
        res.bit_idx  = '0;
        res.new_word = '1;
      end
      pfba_pkg::OP_FREE_PAGE: begin
        res.hit      = 1'b1;
        res.bit_idx  = ctl.bit_sel;
        res.new_word = word & ~(pfba_pkg::WORD_W'(1) << ctl.bit_sel);
      end
      default: begin
        res.hit      = 1'b0;
        res.bit_idx  = '0;
        res.new_word = word;
      end
    endcase
  end

endmodule

### rtl/page_frame_bitmap_allocator.sv
// Page frame bitmap allocator: a sequencer scans the bitmap RAM one word per cycle.
// An allocation scans from word 0 until a word hits or the active count is reached;
// a free reads and writes back its word, and a range failure goes straight to S_DONE.
// One request is in flight at a time. After rst the RAM is cleared, with in_ready low.
// Depends on pfba_pkg, pfba_ram and pfba_word_unit.
module page_frame_bitmap_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [pfba_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pfba_pkg::OP_W-1:0]    operation,
  input  logic [pfba_pkg::PAGE_W-1:0]  page_number,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pfba_pkg::PAGE_W-1:0]  result_page,
  output logic [pfba_pkg::STATUS_W-1:0] status
);

  pfba_pkg::state_t state, state_next;

  logic [pfba_pkg::CFG_W-1:0]    words_in_use;
  logic [pfba_pkg::CFG_W-1:0]    active_n;
  logic [pfba_pkg::CFG_W-1:0]    idx, idx_next;
  logic [pfba_pkg::ADDR_W-1:0]   chk_idx, chk_idx_next;
  logic                          pend, pend_next;
  pfba_pkg::op_t                 req_op, req_op_next;
  logic [pfba_pkg::PAGE_W-1:0]   req_page, req_page_next;
  logic [pfba_pkg::PAGE_W-1:0]   res_page, res_page_next;
  pfba_pkg::stat_t               res_status, res_status_next;
  logic                          out_valid_r, out_valid_next;
  logic [pfba_pkg::PAGE_W-1:0]   out_page, out_page_next;
  pfba_pkg::stat_t               out_status, out_status_next;

  logic                          mem_we;
  logic [pfba_pkg::ADDR_W-1:0]   mem_waddr;
  logic [pfba_pkg::WORD_W-1:0]   mem_wdata;
  logic [pfba_pkg::ADDR_W-1:0]   mem_raddr;
  logic [pfba_pkg::WORD_W-1:0]   mem_rdata;

  pfba_pkg::unit_ctl_t           unit_ctl;
  pfba_pkg::unit_res_t           unit_res;

  logic [pfba_pkg::ADDR_W-1:0]   free_word;
  logic                          free_in_range;

  pfba_ram #(
    .WIDTH(pfba_pkg::WORD_W),
    .DEPTH(pfba_pkg::MAX_WORDS)
  ) u_bitmap (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  pfba_word_unit u_word_unit (
    .word(mem_rdata),
    .ctl (unit_ctl),
    .res (unit_res)
  );

  assign active_n = (words_in_use > pfba_pkg::MAX_COUNT) ? pfba_pkg::MAX_COUNT : words_in_use;
  assign free_in_range = {1'b0, page_number} < {active_n, pfba_pkg::BIT_W'(0)};
  assign free_word = req_page[pfba_pkg::PAGE_W-1 -: pfba_pkg::ADDR_W];

  assign out_valid   = out_valid_r;
  assign result_page = out_page;
  assign status      = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pfba_pkg::S_CLEAR;
      words_in_use <= pfba_pkg::CFG_RESET;
      idx          <= '0;
      pend         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      pend        <= pend_next;
      out_valid_r <= out_valid_next;
      if (cfg_wr_en) begin
        words_in_use <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_idx    <= chk_idx_next;
    req_op     <= req_op_next;
    req_page   <= req_page_next;
    res_page   <= res_page_next;
    res_status <= res_status_next;
    out_page   <= out_page_next;
    out_status <= out_status_next;
  end

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    chk_idx_next     = chk_idx;
    pend_next        = pend;
    req_op_next      = req_op;
    req_page_next    = req_page;
    res_page_next    = res_page;
    res_status_next  = res_status;
    out_valid_next   = out_valid_r && !out_ready;
    out_page_next    = out_page;
    out_status_next  = out_status;
    in_ready         = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = chk_idx;
    mem_wdata        = unit_res.new_word;
    mem_raddr        = idx[pfba_pkg::ADDR_W-1:0];
    unit_ctl.op      = req_op;
    unit_ctl.bit_sel = req_page[pfba_pkg::BIT_W-1:0];

    unique case (state)
      pfba_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx[pfba_pkg::ADDR_W-1:0];
        mem_wdata = '0;
        if (idx[pfba_pkg::ADDR_W-1:0] == pfba_pkg::LAST_ADDR) begin
          idx_next   = '0;
          state_next = pfba_pkg::S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      pfba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_op_next   = pfba_pkg::op_t'(operation);
          req_page_next = page_number;
          idx_next      = '0;
          pend_next     = 1'b0;
          res_page_next = '0;
          unique case (pfba_pkg::op_t'(operation)) inside
            pfba_pkg::OP_ALLOC_PAGE, pfba_pkg::OP_ALLOC_BLOCK: begin
              if (active_n == '0) begin
                res_status_next = pfba_pkg::STAT_NONE;
                state_next      = pfba_pkg::S_DONE;
              end else begin
                state_next = pfba_pkg::S_SCAN;
              end
            end
            pfba_pkg::OP_FREE_PAGE: begin
              if (free_in_range) begin
                state_next = pfba_pkg::S_FREE_RD;
              end else begin
                res_status_next = pfba_pkg::STAT_RANGE;
                state_next      = pfba_pkg::S_DONE;
              end
            end
            default: begin
              res_status_next = pfba_pkg::STAT_RANGE;
              state_next      = pfba_pkg::S_DONE;
            end
          endcase
        end
      end
      pfba_pkg::S_SCAN: begin
        if (pend && unit_res.hit) begin
          mem_we          = 1'b1;
          mem_waddr       = chk_idx;
          res_page_next   = {chk_idx, unit_res.bit_idx};
          res_status_next = pfba_pkg::STAT_OK;
          pend_next       = 1'b0;
          state_next      = pfba_pkg::S_DONE;
        end else if (idx < active_n) begin
          mem_raddr    = idx[pfba_pkg::ADDR_W-1:0];
          chk_idx_next = idx[pfba_pkg::ADDR_W-1:0];
          idx_next     = idx + 1'b1;
          pend_next    = 1'b1;
        end else begin
          res_page_next   = '0;
          res_status_next = pfba_pkg::STAT_NONE;
          pend_next       = 1'b0;
          state_next      = pfba_pkg::S_DONE;
        end
      end
      pfba_pkg::S_FREE_RD: begin
        mem_raddr  = free_word;
        state_next = pfba_pkg::S_FREE_WR;
      end
      pfba_pkg::S_FREE_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = free_word;
        res_page_next   = '0;
        res_status_next = pfba_pkg::STAT_OK;
        state_next      = pfba_pkg::S_DONE;
      end
      pfba_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_next  = 1'b1;
          out_page_next   = res_page;
          out_status_next = res_status;
          state_next      = pfba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pfba_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### sim/tb_page_frame_bitmap_allocator.sv
// Testbench for page_frame_bitmap_allocator: directed and random allocate, block and free
// requests, checked beat by beat against a bitmap predictor kept in this file.
// Depends on pfba_pkg and page_frame_bitmap_allocator.
`timescale 1ns / 100ps

module tb_page_frame_bitmap_allocator;

  localparam int QUIET_LIMIT = 20000;

  typedef struct packed {
    logic [pfba_pkg::PAGE_W-1:0] page;
    pfba_pkg::stat_t             st;
  } grant_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_wr_en;
  logic [pfba_pkg::CFG_W-1:0]    cfg_wr_data;
  logic                          in_valid;
  logic                          in_ready;
  logic [pfba_pkg::OP_W-1:0]     operation;
  logic [pfba_pkg::PAGE_W-1:0]   page_number;
  logic                          out_valid;
  logic                          out_ready;
  logic [pfba_pkg::PAGE_W-1:0]   result_page;
  logic [pfba_pkg::STATUS_W-1:0] status;

  logic [pfba_pkg::WORD_W-1:0] frame_map [pfba_pkg::MAX_WORDS];
  logic [pfba_pkg::CFG_W-1:0]  words_cfg;
  grant_t                      expected_grants[$];
  int                          errors = 0;
  int                          idle_pct = 6;
  logic                        rx_hold = 1'b0;
  int                          quiet_cycles = 0;

  page_frame_bitmap_allocator uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .page_number(page_number),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_page(result_page),
    .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int active_count();
    return (words_cfg > pfba_pkg::MAX_COUNT) ? pfba_pkg::MAX_WORDS : int'(words_cfg);
  endfunction

  // Applies one request to the local bitmap and returns the grant it should produce.
  function automatic void bitmap_apply(input pfba_pkg::op_t op,
                                       input logic [pfba_pkg::PAGE_W-1:0] page,
                                       output grant_t grant);
    int n;
    int w;
    int b;
    n = active_count();
    grant.page = '0;
    grant.st = pfba_pkg::STAT_NONE;
    case (op)
      pfba_pkg::OP_ALLOC_PAGE: begin
        for (w = 0; w < n && grant.st != pfba_pkg::STAT_OK; w++) begin
          if (frame_map[w] != '1) begin
            b = 0;
            while (frame_map[w][b]) b++;
            frame_map[w][b] = 1'b1;
            grant.page = pfba_pkg::PAGE_W'(w * pfba_pkg::WORD_W + b);
            grant.st = pfba_pkg::STAT_OK;
          end
        end
      end
      pfba_pkg::OP_ALLOC_BLOCK: begin
        for (w = 0; w < n && grant.st != pfba_pkg::STAT_OK; w++) begin
          if (frame_map[w] == '0) begin
            frame_map[w] = '1;
            grant.page = pfba_pkg::PAGE_W'(w * pfba_pkg::WORD_W);
            grant.st = pfba_pkg::STAT_OK;
          end
        end
      end
      pfba_pkg::OP_FREE_PAGE: begin
        if (int'(page) < n * pfba_pkg::WORD_W) begin
          frame_map[page >> pfba_pkg::BIT_W][page[pfba_pkg::BIT_W-1:0]] = 1'b0;
          grant.st = pfba_pkg::STAT_OK;
        end else begin
          grant.st = pfba_pkg::STAT_RANGE;
        end
      end
      default: grant.st = pfba_pkg::STAT_RANGE;
    endcase
  endfunction

  task automatic send_request(input pfba_pkg::op_t op,
                              input logic [pfba_pkg::PAGE_W-1:0] page);
    grant_t grant;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    page_number <= page;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bitmap_apply(op, page, grant);
    expected_grants.push_back(grant);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_words(input logic [pfba_pkg::CFG_W-1:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    words_cfg = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Grant checker and receiver ready.
  always @(posedge clk) begin
    grant_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected beat, result_page %0d status %0d", $time, result_page,
                 status);
        errors++;
      end else begin
        want = expected_grants.pop_front();
        if (result_page !== want.page) begin
          $display("%0t: result_page expected %0d actual %0d", $time, want.page,
                   result_page);
          errors++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          errors++;
        end
      end
    end
    out_ready <= !rx_hold && ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic test_basic_ops();
    send_request(pfba_pkg::OP_ALLOC_BLOCK, '0);
    send_request(pfba_pkg::OP_ALLOC_PAGE, '1);
    send_request(pfba_pkg::OP_ALLOC_BLOCK, '1);
    send_request(pfba_pkg::OP_FREE_PAGE, pfba_pkg::PAGE_W'(32));
    send_request(pfba_pkg::OP_FREE_PAGE, pfba_pkg::PAGE_W'(32));
    send_request(pfba_pkg::OP_ALLOC_PAGE, '0);
    send_request(pfba_pkg::OP_FREE_PAGE, '1);
    send_request(pfba_pkg::OP_UNUSED, '1);
  endtask

  task automatic test_single_word();
    write_words(pfba_pkg::CFG_W'(1));
    send_request(pfba_pkg::OP_ALLOC_PAGE, '0);
    send_request(pfba_pkg::OP_ALLOC_BLOCK, '0);
    send_request(pfba_pkg::OP_FREE_PAGE, pfba_pkg::PAGE_W'(32));
    send_request(pfba_pkg::OP_FREE_PAGE, pfba_pkg::PAGE_W'(31));
    send_request(pfba_pkg::OP_ALLOC_PAGE, '0);
    send_request(pfba_pkg::OP_FREE_PAGE, '0);
    send_request(pfba_pkg::OP_FREE_PAGE, '0);
  endtask

  task automatic test_zero_words();
    write_words('0);
    send_request(pfba_pkg::OP_ALLOC_PAGE, '0);
    send_request(pfba_pkg::OP_ALLOC_BLOCK, '0);
    send_request(pfba_pkg::OP_FREE_PAGE, '0);
  endtask

  task automatic test_clamped_count();
    write_words('1);
    send_request(pfba_pkg::OP_FREE_PAGE, '1);
    send_request(pfba_pkg::OP_ALLOC_PAGE, '0);
    send_request(pfba_pkg::OP_ALLOC_BLOCK, '0);
  endtask

  // The receiver stalls while requests keep coming, so the block backs up its input.
  task automatic test_backpressure();
    int k;
    pfba_pkg::op_t op;
    write_words(pfba_pkg::CFG_W'(2));
    fork
      begin
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    for (k = 0; k < 8; k++) begin
      if (k % 3 == 2) op = pfba_pkg::OP_FREE_PAGE;
      else op = pfba_pkg::OP_ALLOC_PAGE;
      send_request(op, pfba_pkg::PAGE_W'(k * 7));
    end
  endtask

  task automatic test_random_mix();
    int ph;
    int k;
    int r;
    int span;
    pfba_pkg::op_t op;
    logic [pfba_pkg::PAGE_W-1:0] page;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_words(pfba_pkg::CFG_W'(3));
        1: write_words(pfba_pkg::CFG_W'(1));
        2: write_words(pfba_pkg::CFG_W'($urandom_range(2, 12)));
        3: write_words(pfba_pkg::CFG_W'(1024));
        4: write_words(pfba_pkg::CFG_W'($urandom_range(1, 2047)));
        default: write_words(pfba_pkg::CFG_W'(2));
      endcase
      idle_pct = (ph == 2) ? 0 : 6;
      span = ((active_count() < 16) ? active_count() : 16) * pfba_pkg::WORD_W + 3;
      for (k = 0; k < 90; k++) begin
        r = $urandom_range(99);
        if (r < 40) op = pfba_pkg::OP_ALLOC_PAGE;
        else if (r < 55) op = pfba_pkg::OP_ALLOC_BLOCK;
        else if (r < 97) op = pfba_pkg::OP_FREE_PAGE;
        else op = pfba_pkg::OP_UNUSED;
        if (op == pfba_pkg::OP_FREE_PAGE && $urandom_range(3) != 0)
          page = pfba_pkg::PAGE_W'($urandom_range(0, span));
        else
          page = pfba_pkg::PAGE_W'($urandom_range(0, 32767));
        send_request(op, page);
      end
    end
    idle_pct = 6;
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    operation = '0;
    page_number = '0;
    out_ready = 1'b0;
    words_cfg = pfba_pkg::CFG_RESET;
    foreach (frame_map[i]) frame_map[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_single_word();
    test_zero_words();
    test_clamped_count();
    test_backpressure();
    test_random_mix();
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
